// ----- src/integer_divider_signed_unsigned_assert.svh -----
// ----------------------------------------------------------------------------
// Integer divider assertion macros
// Clocked assertion wrappers used by the checker file of the divider.
// ----------------------------------------------------------------------------
`ifndef INTEGER_DIVIDER_SIGNED_UNSIGNED_ASSERT_SVH
`define INTEGER_DIVIDER_SIGNED_UNSIGNED_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define IDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition is followed by another one on the next edge.
`define IDS_ASSERT_NEXT(lbl, cond, prop, msg) \
  `IDS_ASSERT(lbl, (cond) |=> (prop), msg)

`endif

// ----- src/ids_pkg.sv -----
// ----------------------------------------------------------------------------
// Integer divider package
// Widths, operation kinds, state codes and the structs passed between units.
// ----------------------------------------------------------------------------
package ids_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned HalfW = 32;
  localparam int unsigned CntW  = 6;

  localparam logic [CntW-1:0] TopWide   = 6'd63;
  localparam logic [CntW-1:0] TopNarrow = 6'd31;

  typedef enum logic [1:0] {
    KIND_U32 = 2'd0,
    KIND_S32 = 2'd1,
    KIND_U64 = 2'd2,
    KIND_S64 = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIX  = 4'b1000
  } state_e;

  typedef struct packed {
    logic             wide;
    logic             neg;
    logic             dz;
    logic [DataW-1:0] n;
    logic [DataW-1:0] d;
  } ids_op_t;

  typedef struct packed {
    logic start;
    logic wide;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

endpackage

// ----- src/integer_divider_signed_unsigned.sv -----
// ----------------------------------------------------------------------------
// Integer divider, signed and unsigned, 32-bit and 64-bit
// Use: a slave stream beat carries the dividend (tdata bits 63:0), the
// divisor (tdata bits 127:64) and the kind in tuser: unsigned or signed,
// 32-bit or 64-bit. The master stream returns one beat per request with the
// quotient in tdata and the divide-by-zero flag in tuser.
// The quotient is found one bit per cycle, so the width of the operation
// sets the time: a request passes through one load step, 32 or 64
// shift-subtract steps, a hand-over through the core's done flag and one
// sign-fix step before the result beat. A zero divisor skips the
// shift-subtract steps and goes from the load step to the sign-fix step.
// One request is worked at a time; the next is taken in the cycle after the
// previous quotient enters the output register, so no new request is taken
// while one is in progress.
// Reset clears the control state and empties the output register.
// If the receiver stalls, the result beat is held unchanged, one further
// request may still be accepted and computed, and it then waits for the
// output register to free up.
// ----------------------------------------------------------------------------
module integer_divider_signed_unsigned (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [2*ids_pkg::DataW-1:0]   s_axis_tdata,  // dividend, divisor
  input  logic [1:0]                    s_axis_tuser,  // kind
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ids_pkg::DataW-1:0]     m_axis_tdata,  // quotient
  output logic [0:0]                    m_axis_tuser   // divide_by_zero
);
  import ids_pkg::*;

  state_e           state_q, state_d;
  ids_op_t          op;
  core_ctrl_t       core_ctrl;
  core_stat_t       core_stat;
  logic [DataW-1:0] core_q;
  logic             accept;
  logic             out_load;
  logic [DataW-1:0] fix_quot;
  logic             out_valid_q;
  logic [DataW-1:0] out_data_q;
  logic             out_dz_q;

  assign accept = s_axis_tvalid && s_axis_tready;

  ids_prep u_prep (
    .clk_i     (clk_i),
    .load_i    (accept),
    .kind_i    (kind_e'(s_axis_tuser)),
    .dividend_i(s_axis_tdata[DataW-1:0]),
    .divisor_i (s_axis_tdata[2*DataW-1:DataW]),
    .op_o      (op)
  );

  assign core_ctrl.start = (state_q == ST_LOAD) && !op.dz;
  assign core_ctrl.wide  = op.wide;

  ids_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(core_ctrl),
    .n_i   (op.n),
    .d_i   (op.d),
    .stat_o(core_stat),
    .q_o   (core_q)
  );

  assign out_load = (state_q == ST_FIX) && (!out_valid_q || m_axis_tready);

  always_comb begin
    if (op.dz) begin
      fix_quot = op.wide ? {DataW{1'b1}} : {{(DataW-HalfW){1'b0}}, {HalfW{1'b1}}};
    end else begin
      fix_quot = op.neg ? (~core_q + 1'b1) : core_q;
      if (!op.wide) begin
        fix_quot[DataW-1:HalfW] = '0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = op.dz ? ST_FIX : ST_DIV;
      end
      ST_DIV: begin
        if (core_stat.done) state_d = ST_FIX;
      end
      ST_FIX: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= fix_quot;
      out_dz_q   <= op.dz;
    end
  end

  assign s_axis_tready   = (state_q == ST_IDLE);
  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_dz_q;

endmodule

// ----- src/ids_prep.sv -----
// ----------------------------------------------------------------------------
// Integer divider operand stage
// Registers an accepted beat as operand magnitudes with sign and zero flags.
// ----------------------------------------------------------------------------
module ids_prep (
  input  logic                    clk_i,
  input  logic                    load_i,
  input  ids_pkg::kind_e          kind_i,
  input  logic [ids_pkg::DataW-1:0] dividend_i,
  input  logic [ids_pkg::DataW-1:0] divisor_i,
  output ids_pkg::ids_op_t        op_o
);
  import ids_pkg::*;

  logic             wide;
  logic             sgn;
  logic [DataW-1:0] mask;
  logic [DataW-1:0] n_m;
  logic [DataW-1:0] d_m;
  logic             n_neg;
  logic             d_neg;
  ids_op_t          op_d;
  ids_op_t          op_q;

  always_comb begin
    wide  = (kind_i == KIND_U64) || (kind_i == KIND_S64);
    sgn   = (kind_i == KIND_S32) || (kind_i == KIND_S64);
    mask  = wide ? {DataW{1'b1}} : {{(DataW-HalfW){1'b0}}, {HalfW{1'b1}}};
    n_m   = dividend_i & mask;
    d_m   = divisor_i & mask;
    n_neg = sgn && (wide ? n_m[DataW-1] : n_m[HalfW-1]);
    d_neg = sgn && (wide ? d_m[DataW-1] : d_m[HalfW-1]);
    op_d.wide = wide;
    op_d.neg  = n_neg ^ d_neg;
    op_d.dz   = (d_m == '0);
    op_d.n    = n_neg ? ((~n_m + 1'b1) & mask) : n_m;
    op_d.d    = d_neg ? ((~d_m + 1'b1) & mask) : d_m;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      op_q <= op_d;
    end
  end

  assign op_o = op_q;

endmodule

// ----- src/ids_core.sv -----
// ----------------------------------------------------------------------------
// Integer divider shift-subtract core
// Restoring division, one quotient bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module ids_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ids_pkg::core_ctrl_t       ctrl_i,
  input  logic [ids_pkg::DataW-1:0] n_i,
  input  logic [ids_pkg::DataW-1:0] d_i,
  output ids_pkg::core_stat_t       stat_o,
  output logic [ids_pkg::DataW-1:0] q_o
);
  import ids_pkg::*;

  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] acc_q, acc_d;
  logic [DataW-1:0] div_q, div_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DataW+1:0] diff;
  logic             take;

  // The dividend shifts out at the top while quotient bits shift in below.
  always_comb begin
    diff   = {1'b0, rem_q, acc_q[DataW-1]} - {2'b00, div_q};
    take   = !diff[DataW+1];
    rem_d  = rem_q;
    acc_d  = acc_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      rem_d  = '0;
      acc_d  = ctrl_i.wide ? n_i : {n_i[HalfW-1:0], {(DataW-HalfW){1'b0}}};
      div_d  = d_i;
      cnt_d  = ctrl_i.wide ? TopWide : TopNarrow;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = take ? diff[DataW-1:0] : {rem_q[DataW-2:0], acc_q[DataW-1]};
      acc_d = {acc_q[DataW-2:0], take};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    acc_q <= acc_d;
    div_q <= div_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign q_o         = acc_q;

endmodule

// ----- src/ids_checker.sv -----
// ----------------------------------------------------------------------------
// Integer divider port checker
// Watches the stream ports of the divider over time.
// ----------------------------------------------------------------------------
`include "integer_divider_signed_unsigned_assert.svh"

module ids_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [ids_pkg::DataW-1:0] m_axis_tdata,
  input logic [0:0]                m_axis_tuser
);
  import ids_pkg::*;

  `IDS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result beat dropped while stalled")
  `IDS_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")
  `IDS_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready && !$rose(m_axis_tvalid), "request taken while one is in progress")
  `IDS_ASSERT(a_dz_ones, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[HalfW-1:0] == {HalfW{1'b1}}, "zero divisor without all-ones quotient")

endmodule

bind integer_divider_signed_unsigned ids_checker u_ids_checker (.*);
